// ===== rtl/base64_stream_codec_defines.svh =====
// Assertion macros shared by the base64 codec checker.
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define B64C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define B64C_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked during reset as well.
`define B64C_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/b64c_pkg.sv =====
// Shared types, constants and character functions for the base64 codec.
package b64c_pkg;

  localparam int unsigned RES_MAX = 4;
  localparam int unsigned CNT_W   = $clog2(RES_MAX + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } b64c_res_t;

  // Results of one input beat, slot 0 goes out first.
  typedef struct packed {
    b64c_res_t [RES_MAX-1:0] res;
    logic [CNT_W-1:0]        cnt;
  } b64c_bundle_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } b64c_mode_e;

  // 6-bit value to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] six);
    logic [7:0] v;
    v = {2'b00, six};
    if (six < 6'd26) begin
      enc_char = v + 8'd65;
    end else if (six < 6'd52) begin
      enc_char = v + 8'd71;
    end else if (six < 6'd62) begin
      enc_char = v - 8'd4;
    end else if (six == 6'd62) begin
      enc_char = 8'h2B;
    end else begin
      enc_char = 8'h2F;
    end
  endfunction

  // Character to {invalid, value}; invalid characters give value 0.
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      dec_sextet = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      dec_sextet = {1'b0, 6'(c - 8'd71)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      dec_sextet = {1'b0, 6'(c + 8'd4)};
    end else if (c == 8'h2B) begin
      dec_sextet = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      dec_sextet = {1'b0, 6'd63};
    end else begin
      dec_sextet = {1'b1, 6'd0};
    end
  endfunction

endpackage

// ===== rtl/b64c_core.sv =====
// Input register, group state and per-beat result computation.
module b64c_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [7:0]            s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  free_i,
  output logic                  load_o,
  output b64c_pkg::b64c_bundle_t bundle_o
);

  logic                    inv_q;
  logic [7:0]              in_data_q;
  logic                    in_last_q;
  b64c_pkg::b64c_mode_e    mode_q, mode_d;
  logic [23:0]             grp_bits_q, grp_bits_d;
  logic [1:0]              grp_cnt_q, grp_cnt_d;
  logic [1:0]              pad_q, pad_d;
  logic                    bad_q, bad_d;

  logic                    proc;
  logic [1:0]              enc_gc;
  logic [23:0]             ebits;
  logic                    enc_emit;
  logic [6:0]              dsx;
  logic                    is_pad;
  logic [5:0]              dval;
  logic [1:0]              pad_n;
  logic                    bad_n;
  logic                    bad_g;
  logic [23:0]             dbits;
  logic [1:0]              nbytes;
  b64c_pkg::b64c_bundle_t  enc_bnd, dec_bnd, flag_bnd;

  assign proc       = inv_q && free_i;
  assign s_tready_o = !inv_q || free_i;
  assign load_o     = proc;

  // Encode path
  always_comb begin
    enc_gc = (grp_cnt_q > 2'd2) ? 2'd2 : grp_cnt_q;
    case (enc_gc)
      2'd0:    ebits = grp_bits_q | {in_data_q, 16'h0000};
      2'd1:    ebits = grp_bits_q | {8'h00, in_data_q, 8'h00};
      default: ebits = grp_bits_q | {16'h0000, in_data_q};
    endcase
    enc_emit = (enc_gc == 2'd2) || in_last_q;
    enc_bnd  = '0;
    enc_bnd.cnt = b64c_pkg::CNT_W'(b64c_pkg::RES_MAX);
    for (int k = 0; k < b64c_pkg::RES_MAX; k++) begin
      enc_bnd.res[k].data = b64c_pkg::enc_char(ebits[23-6*k -: 6]);
      enc_bnd.res[k].last = 1'b0;
      enc_bnd.res[k].bad  = 1'b0;
    end
    // short final group: pad the trailing characters
    if (enc_gc == 2'd0) enc_bnd.res[2].data = b64c_pkg::PAD_CHAR;
    if (enc_gc != 2'd2) enc_bnd.res[3].data = b64c_pkg::PAD_CHAR;
    enc_bnd.res[3].last = in_last_q;
  end

  // Decode path
  always_comb begin
    dsx    = b64c_pkg::dec_sextet(in_data_q);
    is_pad = (in_data_q == b64c_pkg::PAD_CHAR);
    dval   = is_pad ? 6'd0 : dsx[5:0];
    pad_n  = (is_pad && pad_q != 2'd3) ? pad_q + 2'd1 : pad_q;
    // data after padding also spoils the group
    bad_n  = bad_q | (!is_pad && (dsx[6] || pad_q != 2'd0));
    case (grp_cnt_q)
      2'd0:    dbits = grp_bits_q | {dval, 18'h0};
      2'd1:    dbits = grp_bits_q | {6'h0, dval, 12'h0};
      2'd2:    dbits = grp_bits_q | {12'h0, dval, 6'h0};
      default: dbits = grp_bits_q | {18'h0, dval};
    endcase
    bad_g  = bad_n | (pad_n == 2'd3);
    nbytes = 2'd3 - pad_n;
    dec_bnd = '0;
    dec_bnd.cnt = {1'b0, nbytes};
    for (int k = 0; k < 3; k++) begin
      dec_bnd.res[k].data = dbits[23-8*k -: 8];
      dec_bnd.res[k].last = in_last_q && (2'(k) == nbytes - 2'd1);
      dec_bnd.res[k].bad  = bad_g;
    end
    flag_bnd = '0;
    flag_bnd.cnt = b64c_pkg::CNT_W'(1);
    flag_bnd.res[0].last = 1'b1;
    flag_bnd.res[0].bad  = 1'b1;
  end

  always_comb begin
    mode_d     = mode_q;
    grp_bits_d = grp_bits_q;
    grp_cnt_d  = grp_cnt_q;
    pad_d      = pad_q;
    bad_d      = bad_q;
    bundle_o   = '0;
    if (cfg_we_i) begin
      mode_d     = b64c_pkg::b64c_mode_e'(cfg_wdata_i);
      grp_bits_d = '0;
      grp_cnt_d  = '0;
      pad_d      = '0;
      bad_d      = 1'b0;
    end else if (proc) begin
      grp_bits_d = '0;
      grp_cnt_d  = '0;
      pad_d      = '0;
      bad_d      = 1'b0;
      if (mode_q == b64c_pkg::MODE_ENCODE) begin
        if (enc_emit) begin
          bundle_o = enc_bnd;
        end else begin
          grp_bits_d = ebits;
          grp_cnt_d  = enc_gc + 2'd1;
        end
      end else if (grp_cnt_q != 2'd3) begin
        if (in_last_q) begin
          bundle_o = flag_bnd;   // stream ended mid-group
        end else begin
          grp_bits_d = dbits;
          grp_cnt_d  = grp_cnt_q + 2'd1;
          pad_d      = pad_n;
          bad_d      = bad_n;
        end
      end else if (nbytes == 2'd0) begin
        if (in_last_q) bundle_o = flag_bnd;
      end else begin
        bundle_o = dec_bnd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q      <= 1'b0;
      mode_q     <= b64c_pkg::MODE_ENCODE;
      grp_bits_q <= '0;
      grp_cnt_q  <= '0;
      pad_q      <= '0;
      bad_q      <= 1'b0;
    end else begin
      if (s_tready_o) inv_q <= s_tvalid_i;
      mode_q     <= mode_d;
      grp_bits_q <= grp_bits_d;
      grp_cnt_q  <= grp_cnt_d;
      pad_q      <= pad_d;
      bad_q      <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_data_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

endmodule

// ===== rtl/b64c_out.sv =====
// Result register: holds a beat's results, one sent per cycle unless stalled.
module b64c_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  b64c_pkg::b64c_bundle_t bundle_i,
  output logic                   free_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [7:0]             m_tdata_o,
  output logic                   m_tlast_o,
  output logic                   m_tuser_o
);

  b64c_pkg::b64c_res_t [b64c_pkg::RES_MAX-1:0] res_q, res_d;
  logic [b64c_pkg::CNT_W-1:0]                 cnt_q, cnt_d;
  logic                                       drain;

  assign drain  = (cnt_q != '0) && m_tready_i;
  // free when empty or when the final result leaves this cycle
  assign free_o = (cnt_q == '0) ||
                  (cnt_q == b64c_pkg::CNT_W'(1) && m_tready_i);

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (load_i) begin
      res_d = bundle_i.res;
      cnt_d = bundle_i.cnt;
    end else if (drain) begin
      for (int k = 0; k < b64c_pkg::RES_MAX - 1; k++) begin
        res_d[k] = res_q[k+1];
      end
      cnt_d = cnt_q - b64c_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = res_q[0].data;
  assign m_tlast_o  = res_q[0].last;
  assign m_tuser_o  = res_q[0].bad;

endmodule

// ===== rtl/base64_stream_codec.sv =====
// Top level of the streaming base64 encoder / decoder.
//
//  channel   | dir | tdata          | tlast     | tuser
//  ----------+-----+----------------+-----------+----------
//  s_axis    | in  | in_byte [7:0]  | in_last   | -
//  m_axis    | out | out_byte [7:0] | out_last  | bad_input
//  cfg       | in  | mode (cfg_wdata_i, written when cfg_we_i is high)
//
// A beat waits in the input register until the result register is empty or sends
// its final result; its results are then loaded into the result register and offered.
// Results leave one per cycle while m_axis_tready is high; a full group maps both ways:
// 3 bytes to 4 characters when encoding, 4 characters to 3 bytes when decoding.
// Reset clears the mode to encode and empties the group and both registers.
// A stall on m_axis backs up into s_axis once the input register is full.
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] bad_input
);

  logic                   free;
  logic                   load;
  b64c_pkg::b64c_bundle_t bundle;

  b64c_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .free_i      (free),
    .load_o      (load),
    .bundle_o    (bundle)
  );

  b64c_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .free_o     (free),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

// ===== rtl/b64c_checker.sv =====
// Port-level checks for the base64 codec, bound to the top level.
`include "base64_stream_codec_defines.svh"

module b64c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  logic [9:0] out_beat;
  logic       out_stall;
  logic       s_accept;

  assign out_beat  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign s_accept  = s_axis_tvalid && s_axis_tready;

  // a stalled result beat holds
  `B64C_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat), "beat changed in stall")

  // leaving reset finds the result register empty
  `B64C_ASSERT_RST(a_rst_empty, $rose(rst_ni), !m_axis_tvalid, "result valid out of reset")

  // an empty result register never holds off the input
  `B64C_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled while empty")

  // a new run of results needs a beat taken into the input register, then loaded
  `B64C_ASSERT_IMP(a_out_has_cause, $rose(m_axis_tvalid), $past(s_accept, 2), "no input beat")

endmodule

bind base64_stream_codec b64c_checker u_b64c_checker (.*);
